[hw/rtl/bds_pkg.sv]
// shared types and constants of the best disparity select block
package bds_pkg;

  localparam int COST_W = 32;
  localparam int CONF_W = 17;
  localparam int DISP_W = 12;
  localparam int MIN_DISP_W = 11;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;
  localparam int AMBIG_SHIFT = 20;

  localparam logic [COST_W-1:0] COST_NONE = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] SCALE_MIN = 32'h0001_0000;
  localparam logic [CONF_W-1:0] CONF_ONE = 17'h1_0000;

  // register index as selected by paddr[2]
  localparam logic REG_MIN_DISP = 1'b0;
  localparam logic REG_COST_LIMIT = 1'b1;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic cand;
    logic last;
  } bds_item_t;

  typedef struct packed {
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] second;
    logic found;
    logic many;
  } bds_snap_t;

  typedef struct packed {
    logic [DISP_W-1:0] disparity;
    logic [CONF_W-1:0] confidence;
    logic sel;
    logic found;
  } bds_result_t;

  typedef enum logic [3:0] {
    R_IDLE  = 4'b0001,
    R_CHECK = 4'b0010,
    R_DIV   = 4'b0100,
    R_DONE  = 4'b1000
  } bds_rstate_t;

endpackage

[hw/rtl/bds_front.sv]
// front stage: registers each cost request and classifies it against the limit
module bds_front (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  logic [bds_pkg::COST_W-1:0] cost,
  input  logic cost_valid,
  input  logic last,
  input  logic [bds_pkg::COST_W-1:0] cost_limit,
  output logic q_valid,
  input  logic q_ready,
  output bds_pkg::bds_item_t q_item
);
  import bds_pkg::*;

  logic vld;
  bds_item_t item;

  assign item_ready = !vld || q_ready;
  assign q_valid = vld;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (item_ready) begin
      vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item.cost <= cost;
      item.cand <= cost_valid && (cost < cost_limit);
      item.last <= last;
    end
  end

endmodule

[hw/rtl/bds_queue.sv]
// small register queue between front and back
module bds_queue #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  bds_pkg::bds_item_t push_item,
  output logic pop_valid,
  input  logic pop_ready,
  output bds_pkg::bds_item_t pop_item
);
  import bds_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  bds_item_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid = count != '0;
  assign pop_item = mem[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

[hw/rtl/bds_accum.sv]
// back stage: best/2nd cost per pixel, one per cycle, a last may wait
module bds_accum #(
  parameter int MAX_DISPARITIES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  bds_pkg::bds_item_t q_item,
  output logic snap_valid,
  input  logic snap_ready,
  output bds_pkg::bds_snap_t snap,
  output logic [$clog2(MAX_DISPARITIES)-1:0] snap_index
);
  import bds_pkg::*;

  localparam int IW = $clog2(MAX_DISPARITIES + 1);
  localparam int BW = $clog2(MAX_DISPARITIES);
  localparam logic [IW-1:0] IDX_END = IW'(MAX_DISPARITIES);

  logic [COST_W-1:0] best, best_next;
  logic [COST_W-1:0] second, second_next;
  logic [BW-1:0] best_index, best_index_next;
  logic found, found_next;
  logic many, many_next;
  logic [IW-1:0] idx, idx_next;
  logic in_range;
  logic cand;
  logic take;

  assign q_ready = snap_ready || !q_item.last;
  assign take = q_valid && q_ready;
  assign snap_valid = q_valid && q_item.last;

  always_comb begin
    in_range = idx != IDX_END;
    cand = q_item.cand && in_range;
    best_next = best;
    second_next = second;
    best_index_next = best_index;
    found_next = found;
    many_next = many;
    idx_next = in_range ? idx + 1'b1 : idx;
    if (cand) begin
      if (!found || q_item.cost < best) begin
        second_next = best;
        best_next = q_item.cost;
        best_index_next = idx[BW-1:0];
        found_next = 1'b1;
        many_next = many || found;
      end else begin
        many_next = 1'b1;
        if (q_item.cost < second) begin
          second_next = q_item.cost;
        end
      end
    end
  end

  assign snap.best = best_next;
  assign snap.second = second_next;
  assign snap.found = found_next;
  assign snap.many = many_next;
  assign snap_index = best_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= COST_NONE;
      second <= COST_NONE;
      best_index <= '0;
      found <= 1'b0;
      many <= 1'b0;
      idx <= '0;
    end else if (take) begin
      if (q_item.last) begin
        best <= COST_NONE;
        second <= COST_NONE;
        best_index <= '0;
        found <= 1'b0;
        many <= 1'b0;
        idx <= '0;
      end else begin
        best <= best_next;
        second <= second_next;
        best_index <= best_index_next;
        found <= found_next;
        many <= many_next;
        idx <= idx_next;
      end
    end
  end

endmodule

[hw/rtl/bds_resolve.sv]
// back stage: uniqueness test and bit-serial confidence divide per pixel
module bds_resolve #(
  parameter int MAX_DISPARITIES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic snap_valid,
  output logic snap_ready,
  input  bds_pkg::bds_snap_t snap,
  input  logic [$clog2(MAX_DISPARITIES)-1:0] snap_index,
  input  logic [bds_pkg::MIN_DISP_W-1:0] min_disp,
  output logic res_valid,
  input  logic res_ready,
  output bds_pkg::bds_result_t res
);
  import bds_pkg::*;

  localparam int BW = $clog2(MAX_DISPARITIES);

  bds_rstate_t state;
  bds_snap_t s;
  logic [BW-1:0] index;
  logic [COST_W-1:0] rem;
  logic [CONF_W-1:0] quo;
  logic nbit;
  logic [DIV_CNT_W-1:0] cnt;

  logic [COST_W-1:0] margin;
  logic [COST_W-1:0] scale;
  logic unique_ok;
  logic [COST_W:0] trial;
  logic trial_ge;

  assign snap_ready = state == R_IDLE;
  assign res_valid = state == R_DONE;

  always_comb begin
    margin = s.second - s.best;
    scale = (s.second > SCALE_MIN) ? s.second : SCALE_MIN;
    unique_ok = (margin[COST_W-1:COST_W-AMBIG_SHIFT] != '0)
      || ({margin[COST_W-AMBIG_SHIFT-1:0], {AMBIG_SHIFT{1'b0}}} > scale);
    trial = {rem, nbit};
    trial_ge = trial >= {1'b0, s.second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE: begin
          if (snap_valid) begin
            state <= R_CHECK;
          end
        end
        R_CHECK: begin
          if (s.found && s.many && unique_ok) begin
            state <= R_DIV;
          end else begin
            state <= R_DONE;
          end
        end
        R_DIV: begin
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= R_DONE;
          end
        end
        R_DONE: begin
          if (res_ready) begin
            state <= R_IDLE;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (snap_valid) begin
          s <= snap;
          index <= snap_index;
        end
      end
      R_CHECK: begin
        // no candidate reports disparity zero
        if (s.found) begin
          res.disparity <= {min_disp[MIN_DISP_W-1], min_disp} + DISP_W'(index);
        end else begin
          res.disparity <= '0;
        end
        res.found <= s.found;
        res.confidence <= '0;
        res.sel <= 1'b0;
        if (s.found && !s.many) begin
          res.confidence <= CONF_ONE;
          res.sel <= 1'b1;
        end
        // margin*2^16 >> 17 seeds the remainder, margin lsb is the first shifted bit
        rem <= {1'b0, margin[COST_W-1:1]};
        nbit <= margin[0];
        quo <= '0;
        cnt <= '0;
      end
      R_DIV: begin
        if (trial_ge) begin
          rem <= COST_W'(trial - {1'b0, s.second});
        end else begin
          rem <= trial[COST_W-1:0];
        end
        quo <= {quo[CONF_W-2:0], trial_ge};
        nbit <= 1'b0;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          res.confidence <= {quo[CONF_W-2:0], trial_ge};
          res.sel <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/best_disparity_select.sv]
// top level of the winner-take-all disparity select with uniqueness test
// throughput: one cost request per cycle; a pixel's last request waits while the
//   resolver is still busy with the previous pixel
// result: once the last cost is taken the resolver steps from R_CHECK to R_DONE when no divide is needed,
//   or through R_DIV when the confidence divide runs (17 steps, one quotient bit a cycle)
// reset: synchronous active high rst clears the per-pixel state, the queue and the
//   handshakes, and sets min_disp to 0 and cost_limit to all ones
module best_disparity_select #(
  parameter int MAX_DISPARITIES = 256
) (
  input  logic clk,
  input  logic rst,
  // cost request channel
  input  logic item_valid,
  output logic item_ready,
  input  logic [bds_pkg::COST_W-1:0] cost,
  input  logic cost_valid,
  input  logic last,
  // result channel
  output logic result_valid,
  input  logic result_ready,
  output logic signed [bds_pkg::DISP_W-1:0] disparity,
  output logic [bds_pkg::CONF_W-1:0] confidence,
  output logic selected_valid,
  output logic found,
  // configuration port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import bds_pkg::*;

  localparam int BW = $clog2(MAX_DISPARITIES);

  // configuration registers
  logic [MIN_DISP_W-1:0] min_disp;
  logic [COST_W-1:0] cost_limit;
  logic cfg_wr;

  // front to queue to back
  logic f_valid;
  logic f_ready;
  bds_item_t f_item;
  logic q_valid;
  logic q_ready;
  bds_item_t q_item;

  // accumulator to resolver snapshot
  logic snap_valid;
  logic snap_ready;
  bds_snap_t snap;
  logic [BW-1:0] snap_index;
  bds_result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // paddr[2] picks the register, low address bits are not decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      min_disp <= '0;
      cost_limit <= COST_NONE;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_DISP: min_disp <= pwdata[MIN_DISP_W-1:0];
        REG_COST_LIMIT: cost_limit <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_DISP: prdata = {{(32 - MIN_DISP_W){1'b0}}, min_disp};
      REG_COST_LIMIT: prdata = cost_limit;
      default: prdata = '0;
    endcase
  end

  // front: register the request and flag it as a candidate
  bds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cost       (cost),
    .cost_valid (cost_valid),
    .last       (last),
    .cost_limit (cost_limit),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_item     (f_item)
  );

  // queue lets the front keep taking costs while the back stalls on a last
  bds_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // back: best and second tracking, index counting
  bds_accum #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_index (snap_index)
  );

  // back: uniqueness test, confidence divide and result hold
  bds_resolve #(
    .MAX_DISPARITIES (MAX_DISPARITIES)
  ) u_resolve (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_index (snap_index),
    .min_disp   (min_disp),
    .res_valid  (result_valid),
    .res_ready  (result_ready),
    .res        (res)
  );

  assign disparity = res.disparity;
  assign confidence = res.confidence;
  assign selected_valid = res.sel;
  assign found = res.found;

endmodule
